@@ design/prf_pkg.sv @@
// shared types and constants for the pulse region finder
`timescale 1ns / 1ps
package prf_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int IDX_W     = 13;
  localparam int MAX_BURST = 5;
  localparam int BURST_CW  = $clog2(MAX_BURST + 1);
  localparam int QDEPTH    = 8;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int QCW       = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    MK_BEGIN  = 2'd0,
    MK_PEAK   = 2'd1,
    MK_END    = 2'd2,
    MK_CANCEL = 2'd3
  } marker_kind_t;

  typedef enum logic [1:0] {
    PH_SEEK_START = 2'd0,
    PH_SEEK_PEAK  = 2'd1,
    PH_SEEK_END   = 2'd2
  } phase_t;

  typedef struct packed {
    marker_kind_t      kind;
    logic [IDX_W-1:0]  index;
  } marker_t;

  typedef struct packed {
    logic [BURST_CW-1:0]          count;
    marker_t [MAX_BURST-1:0]      mk;
  } burst_t;

  typedef struct packed {
    marker_t mk;
    logic    last;
  } q_entry_t;

endpackage

@@ design/prf_detect.sv @@
// running sums, region state machine and marker burst for one sample beat
`timescale 1ns / 1ps
module prf_detect #(
  parameter int MAX_SAMPLES = 4096,
  parameter int SUM_WIDTH   = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  accept,
  input  logic signed [prf_pkg::SAMPLE_W-1:0]   sample,
  input  logic                                  last,
  input  logic signed [prf_pkg::SAMPLE_W-1:0]   pe_height,
  output prf_pkg::burst_t                       burst
);
  import prf_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = SUM_WIDTH;
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;
  localparam int DW = SW + 3;
  localparam int LW = SW + 5;

  phase_t                 phase_r, phase_nxt, phase_step;
  logic [CW-1:0]          count_r, count_nxt, count_after;
  logic signed [SW-1:0]   hist_r [9];
  logic signed [SW-1:0]   hist_nxt [9];
  logic [CW-1:0]          lpi_r, lpi_nxt, lpi_step;
  logic                   peak_seen_r, peak_seen_nxt, peak_seen_step;
  logic [IDX_W-1:0]       begin_r, begin_nxt, begin_step;

  logic                   step, act;
  logic [XW-1:0]          idx_x;
  logic [IDX_W-1:0]       idx13;
  logic [CW-1:0]          peak_gap;
  logic signed [SW-1:0]   a3, a6, a9, pe_x, c;
  logic signed [SW:0]     c_wide, diff_a, diff_b;
  logic signed [DW-1:0]   d1, d2;
  logic signed [LW-1:0]   lhs, rhs;
  logic                   rise, fall_hi, above, infl1, infl2;
  logic [XW-1:0]          end_x;

  assign step     = count_r < CW'(MAX_SAMPLES);
  assign act      = step && (count_r >= CW'(3));
  assign idx_x    = XW'(count_r);
  assign idx13    = idx_x[IDX_W-1:0];
  assign peak_gap = count_r - lpi_r;

  assign a3   = hist_r[2];
  assign a6   = hist_r[5];
  assign a9   = hist_r[8];
  assign pe_x = SW'(pe_height);

  // saturating stride-3 sum
  assign c_wide = (SW+1)'(sample) + (SW+1)'(a3);
  always_comb begin
    if (count_r < CW'(3)) begin
      c = '0;
    end else if (c_wide[SW] != c_wide[SW-1]) begin
      c = c_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      c = c_wide[SW-1:0];
    end
  end

  assign d1     = DW'(a6) - (DW'(a3) <<< 1) + DW'(c);
  assign d2     = DW'(a9) - (DW'(a6) <<< 1) + DW'(a3);
  assign diff_a = (SW+1)'(a6) - (SW+1)'(a3);
  assign diff_b = (SW+1)'(a9) - (SW+1)'(a6);
  // 11*x versus 10*y as shift-add
  assign lhs    = (LW'(diff_a) <<< 3) + (LW'(diff_a) <<< 1) + LW'(diff_a);
  assign rhs    = (LW'(diff_b) <<< 3) + (LW'(diff_b) <<< 1);

  assign rise    = a3 < c;
  assign above   = a3 > pe_x;
  assign fall_hi = (a3 > c) && above;
  // a peak in the same step blocks the inflection (distance would be 3)
  assign infl1 = (count_r > CW'(9)) && !d1[DW-1] && (d1 != '0) && d2[DW-1] && above &&
                 (lhs >= rhs) && !fall_hi && (!peak_seen_r || peak_gap > CW'(15));
  assign infl2 = d1[DW-1] && !d2[DW-1] && (d2 != '0) && above &&
                 (peak_gap > CW'(5)) && (lhs <= rhs);

  assign count_after = step ? count_r + CW'(1) : count_r;
  assign end_x       = XW'(count_after);

  // next state
  always_comb begin
    phase_step     = phase_r;
    lpi_step       = lpi_r;
    peak_seen_step = peak_seen_r;
    begin_step     = begin_r;
    if (act) begin
      unique case (phase_r)
        PH_SEEK_START: begin
          if (rise) begin
            phase_step = PH_SEEK_PEAK;
            begin_step = idx13 - IDX_W'(3);
          end else if (fall_hi) begin
            phase_step     = PH_SEEK_END;
            begin_step     = idx13 - IDX_W'(3);
            lpi_step       = count_r - CW'(2);
            peak_seen_step = 1'b1;
          end
        end
        PH_SEEK_PEAK: begin
          if (fall_hi) begin
            phase_step     = PH_SEEK_END;
            lpi_step       = count_r - CW'(3);
            peak_seen_step = 1'b1;
          end
          if (infl1) begin
            begin_step     = idx13 - IDX_W'(6);
            lpi_step       = count_r - CW'(3);
            peak_seen_step = 1'b1;
          end
        end
        PH_SEEK_END: begin
          if (rise) begin
            phase_step = PH_SEEK_START;
          end
          if (infl2) begin
            begin_step     = idx13 - IDX_W'(6);
            lpi_step       = count_r - CW'(3);
            peak_seen_step = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (last) begin
      phase_nxt     = PH_SEEK_START;
      count_nxt     = '0;
      lpi_nxt       = '0;
      peak_seen_nxt = 1'b0;
      begin_nxt     = '0;
    end else begin
      phase_nxt     = phase_step;
      count_nxt     = count_after;
      lpi_nxt       = lpi_step;
      peak_seen_nxt = peak_seen_step;
      begin_nxt     = begin_step;
    end

    for (int k = 0; k < 9; k++) begin
      if (last) begin
        hist_nxt[k] = '0;
      end else if (step) begin
        hist_nxt[k] = (k == 0) ? c : hist_r[(k == 0) ? 0 : k - 1];
      end else begin
        hist_nxt[k] = hist_r[k];
      end
    end
  end

  // marker burst
  always_comb begin
    logic [BURST_CW-1:0] n;
    burst_t              b;
    n = '0;
    b = '0;
    if (act) begin
      unique case (phase_r)
        PH_SEEK_START: begin
          if (rise) begin
            b.mk[n] = '{MK_BEGIN, idx13 - IDX_W'(3)};
            n = n + 1'b1;
          end else if (fall_hi) begin
            b.mk[n] = '{MK_BEGIN, idx13 - IDX_W'(3)};
            n = n + 1'b1;
            b.mk[n] = '{MK_PEAK, idx13 - IDX_W'(2)};
            n = n + 1'b1;
          end
        end
        PH_SEEK_PEAK: begin
          if (fall_hi) begin
            b.mk[n] = '{MK_PEAK, idx13 - IDX_W'(3)};
            n = n + 1'b1;
          end
          if (infl1) begin
            b.mk[n] = '{MK_END, idx13 - IDX_W'(6)};
            n = n + 1'b1;
            b.mk[n] = '{MK_BEGIN, idx13 - IDX_W'(6)};
            n = n + 1'b1;
            b.mk[n] = '{MK_PEAK, idx13 - IDX_W'(3)};
            n = n + 1'b1;
          end
        end
        PH_SEEK_END: begin
          if (rise) begin
            b.mk[n] = '{MK_END, idx13 - IDX_W'(3)};
            n = n + 1'b1;
          end
          if (infl2) begin
            b.mk[n] = '{MK_END, idx13 - IDX_W'(6)};
            n = n + 1'b1;
            b.mk[n] = '{MK_BEGIN, idx13 - IDX_W'(6)};
            n = n + 1'b1;
            b.mk[n] = '{MK_PEAK, idx13 - IDX_W'(3)};
            n = n + 1'b1;
          end
        end
        default: ;
      endcase
    end
    // last sample closes an open region or cancels an open begin
    if (last) begin
      if (phase_step == PH_SEEK_PEAK) begin
        b.mk[n] = '{MK_CANCEL, begin_step};
        n = n + 1'b1;
      end else if (phase_step == PH_SEEK_END) begin
        b.mk[n] = '{MK_END, end_x[IDX_W-1:0]};
        n = n + 1'b1;
      end
    end
    b.count = n;
    burst   = b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SEEK_START;
      count_r     <= '0;
      lpi_r       <= '0;
      peak_seen_r <= 1'b0;
      begin_r     <= '0;
      for (int k = 0; k < 9; k++) hist_r[k] <= '0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      lpi_r       <= lpi_nxt;
      peak_seen_r <= peak_seen_nxt;
      begin_r     <= begin_nxt;
      for (int k = 0; k < 9; k++) hist_r[k] <= hist_nxt[k];
    end
  end

endmodule

@@ design/prf_queue.sv @@
// marker queue: takes a whole burst per beat, hands out one marker per beat
`timescale 1ns / 1ps
module prf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  prf_pkg::burst_t   burst,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output prf_pkg::q_entry_t out_entry
);
  import prf_pkg::*;

  q_entry_t          mem_r [QDEPTH];
  logic [QAW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCW-1:0]    cnt_r, cnt_nxt;
  logic [QCW-1:0]    n_in;
  logic              pop;

  assign room      = cnt_r <= QCW'(QDEPTH - MAX_BURST);
  assign out_valid = cnt_r != '0;
  assign out_entry = mem_r[rp_r];
  assign pop       = out_valid && out_ready;
  assign n_in      = push ? QCW'(burst.count) : '0;

  always_comb begin
    wp_nxt  = wp_r + QAW'(n_in);
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + n_in - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      for (int k = 0; k < MAX_BURST; k++) begin
        if (BURST_CW'(k) < burst.count) begin
          mem_r[wp_r + QAW'(k)] <= '{burst.mk[k], BURST_CW'(k + 1) == burst.count};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ design/pulse_region_finder.sv @@
// pulse region finder top level: config register, detector and marker queue
// markers of a sample are written into the marker queue when its input beat is accepted
// throughput: one sample per cycle while the marker queue has room for a full burst
// of five; one marker leaves per ready cycle; input stalls only when bursts pile up
// reset: synchronous active-low rst_n clears waveform state, pe_height and the queue
`timescale 1ns / 1ps
module pulse_region_finder #(
  parameter int MAX_SAMPLES = 4096,
  parameter int SUM_WIDTH   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic        in_tlast,   // last_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [12:0] sample_index, [15:13] zero
  output logic [1:0]  out_tuser,  // [1:0] marker_kind
  output logic        out_tlast,  // run_last
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [15:0] cfg_tdata   // [15:0] pe_height
);
  import prf_pkg::*;

  logic signed [SAMPLE_W-1:0] pe_height_r;
  logic                       in_accept;
  burst_t                     burst;
  logic                       room;
  q_entry_t                   head;

  assign cfg_tready = 1'b1;
  assign in_tready  = room;
  assign in_accept  = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pe_height_r <= '0;
    end else if (cfg_tvalid) begin
      pe_height_r <= cfg_tdata;
    end
  end

  prf_detect #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SUM_WIDTH   (SUM_WIDTH)
  ) u_detect (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .sample    (in_tdata),
    .last      (in_tlast),
    .pe_height (pe_height_r),
    .burst     (burst)
  );

  prf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .burst     (burst),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_entry (head)
  );

  assign out_tdata = {{(16 - IDX_W){1'b0}}, head.mk.index};
  assign out_tuser = head.mk.kind;
  assign out_tlast = head.last;

endmodule

@@ design/prf_checker.sv @@
// port-level checks for the pulse region finder, bound to the top level
`timescale 1ns / 1ps
module prf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import prf_pkg::*;

  // queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("markers present after reset");

  // input only stalls while markers are waiting
  a_stall_has_markers: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty queue");

  // a cancel always closes the burst of its sample
  a_cancel_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == MK_CANCEL) |-> out_tlast)
    else $error("cancel marker not last of burst");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("out beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      ($stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("out beat changed while stalled");

endmodule

bind pulse_region_finder prf_checker u_prf_checker (.*);
